// ----- src/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, round constants and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package sha_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_UPDATE,
        ST_OUT
    } core_state_t;

    typedef struct packed
    {
        logic [31:0] word;
        logic [5:0]  bits;
        logic        last;
        logic        pad_word;
    } queue_entry_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        case (idx)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] idx);
        case (idx)
            6'd0:    round_const = 32'h428a2f98;
            6'd1:    round_const = 32'h71374491;
            6'd2:    round_const = 32'hb5c0fbcf;
            6'd3:    round_const = 32'he9b5dba5;
            6'd4:    round_const = 32'h3956c25b;
            6'd5:    round_const = 32'h59f111f1;
            6'd6:    round_const = 32'h923f82a4;
            6'd7:    round_const = 32'hab1c5ed5;
            6'd8:    round_const = 32'hd807aa98;
            6'd9:    round_const = 32'h12835b01;
            6'd10:   round_const = 32'h243185be;
            6'd11:   round_const = 32'h550c7dc3;
            6'd12:   round_const = 32'h72be5d74;
            6'd13:   round_const = 32'h80deb1fe;
            6'd14:   round_const = 32'h9bdc06a7;
            6'd15:   round_const = 32'hc19bf174;
            6'd16:   round_const = 32'he49b69c1;
            6'd17:   round_const = 32'hefbe4786;
            6'd18:   round_const = 32'h0fc19dc6;
            6'd19:   round_const = 32'h240ca1cc;
            6'd20:   round_const = 32'h2de92c6f;
            6'd21:   round_const = 32'h4a7484aa;
            6'd22:   round_const = 32'h5cb0a9dc;
            6'd23:   round_const = 32'h76f988da;
            6'd24:   round_const = 32'h983e5152;
            6'd25:   round_const = 32'ha831c66d;
            6'd26:   round_const = 32'hb00327c8;
            6'd27:   round_const = 32'hbf597fc7;
            6'd28:   round_const = 32'hc6e00bf3;
            6'd29:   round_const = 32'hd5a79147;
            6'd30:   round_const = 32'h06ca6351;
            6'd31:   round_const = 32'h14292967;
            6'd32:   round_const = 32'h27b70a85;
            6'd33:   round_const = 32'h2e1b2138;
            6'd34:   round_const = 32'h4d2c6dfc;
            6'd35:   round_const = 32'h53380d13;
            6'd36:   round_const = 32'h650a7354;
            6'd37:   round_const = 32'h766a0abb;
            6'd38:   round_const = 32'h81c2c92e;
            6'd39:   round_const = 32'h92722c85;
            6'd40:   round_const = 32'ha2bfe8a1;
            6'd41:   round_const = 32'ha81a664b;
            6'd42:   round_const = 32'hc24b8b70;
            6'd43:   round_const = 32'hc76c51a3;
            6'd44:   round_const = 32'hd192e819;
            6'd45:   round_const = 32'hd6990624;
            6'd46:   round_const = 32'hf40e3585;
            6'd47:   round_const = 32'h106aa070;
            6'd48:   round_const = 32'h19a4c116;
            6'd49:   round_const = 32'h1e376c08;
            6'd50:   round_const = 32'h2748774c;
            6'd51:   round_const = 32'h34b0bcb5;
            6'd52:   round_const = 32'h391c0cb3;
            6'd53:   round_const = 32'h4ed8aa4a;
            6'd54:   round_const = 32'h5b9cca4f;
            6'd55:   round_const = 32'h682e6ff3;
            6'd56:   round_const = 32'h748f82ee;
            6'd57:   round_const = 32'h78a5636f;
            6'd58:   round_const = 32'h84c87814;
            6'd59:   round_const = 32'h8cc70208;
            6'd60:   round_const = 32'h90befffa;
            6'd61:   round_const = 32'ha4506ceb;
            6'd62:   round_const = 32'hbef9a3f7;
            default: round_const = 32'hc67178f2;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- src/sha256_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// A message arrives as big-endian 32-bit words on the msg channel. The last
// beat carries 0 to 4 valid leading bytes. The eight digest words leave on
// the dig channel, index 0 first, with final_word set on the eighth beat.
// Each message beat is shifted into the block buffer as it leaves the queue.
// A full 64-byte block then runs 64 rounds on the single round unit and
// an update step that folds the result into the hash state. After the last
// beat, the padding words are spread over one or two blocks, and the digest
// leaves one word per cycle while dig_stall is low. A short queue decouples
// msg_stall from the core, so beats are taken while a block is being hashed
// until the queue fills. Reset loads the initial hash values, empties the
// queue and drops dig_valid. While dig_stall is high the current digest
// word holds and the core waits; the queue then fills and msg_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher
#(
    parameter int unsigned QUEUE_DEPTH = sha_pkg::QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        msg_valid,
    output logic             msg_stall,
    input  wire logic [31:0] data_word,
    input  wire logic [2:0]  byte_count,
    input  wire logic        last,
    output logic             dig_valid,
    input  wire logic        dig_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             final_word
);

    sha_pkg::queue_entry_t front_entry;
    sha_pkg::queue_entry_t q_entry;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic                  push;

    assign msg_stall = q_full;
    assign push      = msg_valid && !q_full;

    sha_front u_front
    (
        .data_word  (data_word),
        .byte_count (byte_count),
        .last       (last),
        .entry      (front_entry)
    );

    sha_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    sha_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_entry     (q_entry),
        .q_pop       (q_pop),
        .dig_valid   (dig_valid),
        .dig_stall   (dig_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .final_word  (final_word)
    );

`ifndef NO_ASSERTIONS
    a_final_index: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (final_word == (word_index == 3'd7)))
        else $error("final_word does not match the last digest index");

    a_digest_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (dig_valid && !dig_stall && !final_word)
        |=> (dig_valid && (word_index == $past(word_index) + 3'd1)))
        else $error("digest words are not delivered back to back in order");

    a_digest_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dig_valid) |-> (word_index == 3'd0))
        else $error("digest does not start at word zero");
`endif

endmodule

`default_nettype wire

// ----- src/sha_front.sv -----
// ----------------------------------------------------------------------------
// SHA-256 input classifier
// Turns one input beat into a queue entry: masked and padded word, bit count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_front
(
    input  wire logic [31:0]          data_word,
    input  wire logic [2:0]           byte_count,
    input  wire logic                 last,
    output sha_pkg::queue_entry_t     entry
);

    logic [2:0] count_sat;

    always_comb
    begin
        if (byte_count inside {[3'd4:3'd7]})
        begin
            count_sat = 3'd4;
        end
        else
        begin
            count_sat = byte_count;
        end
    end

    always_comb
    begin
        entry.last     = last;
        entry.pad_word = last && (count_sat == 3'd4);
        if (last)
        begin
            entry.bits = {count_sat, 3'b000};
            case (count_sat)
                3'd0:    entry.word = 32'h8000_0000;
                3'd1:    entry.word = {data_word[31:24], 24'h80_0000};
                3'd2:    entry.word = {data_word[31:16], 16'h8000};
                3'd3:    entry.word = {data_word[31:8], 8'h80};
                default: entry.word = data_word;
            endcase
        end
        else
        begin
            entry.bits = 6'd32;
            entry.word = data_word;
        end
    end

endmodule

`default_nettype wire

// ----- src/sha_queue.sv -----
// ----------------------------------------------------------------------------
// SHA-256 entry queue
// Small FIFO between the input classifier and the hashing core.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_queue
#(
    parameter int unsigned DEPTH = sha_pkg::QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire sha_pkg::queue_entry_t push_entry,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       pop_valid,
    output sha_pkg::queue_entry_t      pop_entry
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    sha_pkg::queue_entry_t entries_reg [DEPTH];
    logic [AW-1:0]         wr_ptr_reg;
    logic [AW-1:0]         wr_ptr_next;
    logic [AW-1:0]         rd_ptr_reg;
    logic [AW-1:0]         rd_ptr_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- src/sha_core.sv -----
// ----------------------------------------------------------------------------
// SHA-256 hashing core
// Loads words into the schedule window, pads, runs rounds and emits digests.
// ----------------------------------------------------------------------------
`default_nettype none

module sha_core
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_valid,
    input  wire sha_pkg::queue_entry_t q_entry,
    output logic                       q_pop,
    output logic                       dig_valid,
    input  wire logic                  dig_stall,
    output logic [31:0]                digest_word,
    output logic [2:0]                 word_index,
    output logic                       final_word
);

    sha_pkg::core_state_t state_reg;
    sha_pkg::core_state_t state_next;

    logic [15:0][31:0] window_reg;
    logic [7:0][31:0]  vars_reg;
    logic [7:0][31:0]  vars_next;
    logic [7:0][31:0]  hash_reg;
    logic [4:0]        fill_reg;
    logic [5:0]        round_reg;
    logic [63:0]       bitlen_reg;
    logic              pad_active_reg;
    logic              pend80_reg;
    logic              len_hi_done_reg;
    logic              final_blk_reg;
    logic [2:0]        out_idx_reg;
    logic              out_valid_reg;
    logic [31:0]       out_word_reg;
    logic [2:0]        out_index_reg;
    logic              out_final_reg;

    logic              shift_en;
    logic [31:0]       shift_word;
    logic              block_full;
    logic              load_out;
    logic [31:0]       sched_word;
    logic [31:0]       t1;
    logic [31:0]       t2;

    assign dig_valid   = out_valid_reg;
    assign digest_word = out_word_reg;
    assign word_index  = out_index_reg;
    assign final_word  = out_final_reg;

    assign sched_word = sha_pkg::small_sigma1(window_reg[14]) + window_reg[9]
                      + sha_pkg::small_sigma0(window_reg[1]) + window_reg[0];

    assign t1 = vars_reg[7] + sha_pkg::big_sigma1(vars_reg[4])
              + ((vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]))
              + sha_pkg::round_const(round_reg) + window_reg[0];
    assign t2 = sha_pkg::big_sigma0(vars_reg[0])
              + ((vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]));

    always_comb
    begin
        vars_next[7] = vars_reg[6];
        vars_next[6] = vars_reg[5];
        vars_next[5] = vars_reg[4];
        vars_next[4] = vars_reg[3] + t1;
        vars_next[3] = vars_reg[2];
        vars_next[2] = vars_reg[1];
        vars_next[1] = vars_reg[0];
        vars_next[0] = t1 + t2;
    end

    assign block_full = (fill_reg == 5'd15);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    if (block_full)
                    begin
                        state_next = sha_pkg::ST_ROUND;
                    end
                    else if (q_entry.last)
                    begin
                        state_next = sha_pkg::ST_PAD;
                    end
                end
            end
            sha_pkg::ST_PAD:
            begin
                if (block_full)
                begin
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = sha_pkg::ST_UPDATE;
                end
            end
            sha_pkg::ST_UPDATE:
            begin
                if (final_blk_reg)
                begin
                    state_next = sha_pkg::ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = sha_pkg::ST_PAD;
                end
                else
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_OUT:
            begin
                if (load_out && (out_idx_reg == 3'd7))
                begin
                    state_next = sha_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop      = 1'b0;
        shift_en   = 1'b0;
        shift_word = 32'h0;
        load_out   = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                q_pop      = q_valid;
                shift_en   = q_valid;
                shift_word = q_entry.word;
            end
            sha_pkg::ST_PAD:
            begin
                shift_en = 1'b1;
                if (pend80_reg)
                begin
                    shift_word = 32'h8000_0000;
                end
                else if (fill_reg == 5'd14)
                begin
                    shift_word = bitlen_reg[63:32];
                end
                else if (block_full && len_hi_done_reg)
                begin
                    shift_word = bitlen_reg[31:0];
                end
            end
            sha_pkg::ST_ROUND:
            begin
                shift_en   = 1'b1;
                shift_word = sched_word;
            end
            sha_pkg::ST_OUT:
            begin
                load_out = !out_valid_reg || !dig_stall;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= sha_pkg::ST_IDLE;
            fill_reg        <= '0;
            round_reg       <= '0;
            bitlen_reg      <= '0;
            pad_active_reg  <= 1'b0;
            pend80_reg      <= 1'b0;
            len_hi_done_reg <= 1'b0;
            final_blk_reg   <= 1'b0;
            out_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= sha_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            if (shift_en && (state_reg != sha_pkg::ST_ROUND))
            begin
                fill_reg <= block_full ? 5'd0 : fill_reg + 5'd1;
            end
            if (state_reg == sha_pkg::ST_ROUND)
            begin
                round_reg <= round_reg + 6'd1;
            end
            if (q_pop)
            begin
                bitlen_reg      <= bitlen_reg + 64'(q_entry.bits);
                pad_active_reg  <= q_entry.last;
                pend80_reg      <= q_entry.pad_word;
                len_hi_done_reg <= 1'b0;
                final_blk_reg   <= 1'b0;
            end
            if (state_reg == sha_pkg::ST_PAD)
            begin
                pend80_reg <= 1'b0;
                if (!pend80_reg && (fill_reg == 5'd14))
                begin
                    len_hi_done_reg <= 1'b1;
                end
                if (!pend80_reg && block_full && len_hi_done_reg)
                begin
                    final_blk_reg <= 1'b1;
                end
            end
            if (state_reg == sha_pkg::ST_UPDATE)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + vars_reg[i];
                end
            end
            if (load_out)
            begin
                out_idx_reg <= out_idx_reg + 3'd1;
                if (out_idx_reg == 3'd7)
                begin
                    bitlen_reg     <= '0;
                    pad_active_reg <= 1'b0;
                    final_blk_reg  <= 1'b0;
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= sha_pkg::init_hash(3'(i));
                    end
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!dig_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                window_reg[i] <= window_reg[i+1];
            end
            window_reg[15] <= shift_word;
        end
        if (shift_en && block_full && (state_reg != sha_pkg::ST_ROUND))
        begin
            vars_reg <= hash_reg;
        end
        else if (state_reg == sha_pkg::ST_ROUND)
        begin
            vars_reg <= vars_next;
        end
        if (load_out)
        begin
            out_word_reg  <= hash_reg[out_idx_reg];
            out_index_reg <= out_idx_reg;
            out_final_reg <= (out_idx_reg == 3'd7);
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_sha256_stream_hasher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds messages of many lengths and last-beat byte counts, hashes each one
// in a local SHA-256 model and checks the eight digest beats in order. Both
// handshakes idle at random in the first two of three phases. One long stall on the digest
// side forces the message input to back up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sha256_stream_hasher;

    localparam logic [64*32-1:0] ROUND_K =
    {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [8*32-1:0] HASH_IV =
    {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam int unsigned HOLD_CYCLES = 500;

    typedef struct packed
    {
        logic [31:0] data;
        logic [2:0]  cnt;
        logic        lst;
    } msg_beat_t;

    typedef struct packed
    {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        fin;
    } digest_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic [31:0] data_word = '0;
    logic [2:0]  byte_count = '0;
    logic        last = 1'b0;
    logic        dig_valid;
    logic        dig_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;

    msg_beat_t    msg_q[$];
    digest_beat_t digest_q[$];

    logic [31:0] hash_st [8];
    logic [31:0] blk [16];
    logic [63:0] msg_bits;
    int unsigned fill_words;

    int unsigned beats_taken = 0;
    int unsigned phase_len = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    int unsigned backed_up = 0;
    int unsigned err_cnt = 0;
    int unsigned words_checked = 0;
    int unsigned msg_cnt = 0;
    int unsigned longest = 0;

    sha256_stream_hasher i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .data_word   (data_word),
        .byte_count  (byte_count),
        .last        (last),
        .dig_valid   (dig_valid),
        .dig_stall   (dig_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .final_word  (final_word)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        ror32 = {x, x} >> n;
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
        begin
            hash_st[i] = HASH_IV[(7 - i) * 32 +: 32];
        end
        msg_bits = '0;
        fill_words = 0;
    endfunction

    function automatic void hash_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
            begin
                w[i] = blk[i];
            end
            else
            begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = s1 + w[i-7] + s0 + w[i-16];
            end
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_st[i];
        end
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[(63 - i) * 32 +: 32] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_st[i] = hash_st[i] + v[i];
        end
    endfunction

    function automatic void append_word(input logic [31:0] w);
        blk[fill_words] = w;
        fill_words++;
        if (fill_words == 16)
        begin
            hash_block();
            fill_words = 0;
        end
    endfunction

    function automatic void hash_beat(input logic [31:0] d, input logic [2:0] c,
                                      input logic l);
        int unsigned n;
        logic [31:0] keep;
        if (!l)
        begin
            msg_bits = msg_bits + 64'd32;
            append_word(d);
            return;
        end
        n = (c > 3'd4) ? 4 : c;
        msg_bits = msg_bits + 64'(n * 8);
        if (n == 4)
        begin
            append_word(d);
            append_word(32'h8000_0000);
        end
        else
        begin
            keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
            append_word((d & keep) | (32'h80 << (24 - 8 * n)));
        end
        if (fill_words > 14)
        begin
            for (int i = fill_words; i < 16; i++)
            begin
                blk[i] = '0;
            end
            hash_block();
            fill_words = 0;
        end
        for (int i = fill_words; i < 14; i++)
        begin
            blk[i] = '0;
        end
        blk[14] = msg_bits[63:32];
        blk[15] = msg_bits[31:0];
        hash_block();
        for (int i = 0; i < 8; i++)
        begin
            digest_q.push_back('{word: hash_st[i], idx: 3'(i), fin: (i == 7)});
        end
        restart_hash();
    endfunction

    function automatic int unsigned idle_pct(input bit rx_side);
        if (beats_taken < phase_len)
        begin
            return rx_side ? 88 : 22;
        end
        if (beats_taken < 2 * phase_len)
        begin
            return rx_side ? 22 : 88;
        end
        return 0;
    endfunction

    task automatic push_beat(input logic [31:0] d, input logic [2:0] c, input logic l);
        msg_q.push_back('{data: d, cnt: c, lst: l});
    endtask

    task automatic add_message(input int unsigned nwords);
        for (int i = 1; i < nwords; i++)
        begin
            push_beat($urandom(), 3'($urandom_range(0, 7)), 1'b0);
        end
        push_beat($urandom(), 3'($urandom_range(0, 7)), 1'b1);
        msg_cnt++;
        if (nwords > longest)
        begin
            longest = nwords;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        msg_beat_t nxt;
        if (!rst_n)
        begin
            msg_valid <= 1'b0;
            data_word <= '0;
            byte_count <= '0;
            last <= 1'b0;
        end
        else
        begin
            if (msg_valid && !msg_stall)
            begin
                hash_beat(data_word, byte_count, last);
                beats_taken <= beats_taken + 1;
            end
            if (!msg_valid || !msg_stall)
            begin
                if (msg_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0))
                begin
                    nxt = msg_q.pop_front();
                    msg_valid <= 1'b1;
                    data_word <= nxt.data;
                    byte_count <= nxt.cnt;
                    last <= nxt.lst;
                end
                else
                begin
                    msg_valid <= 1'b0;
                end
            end
        end
    end

    // A long hold on the digest side early in the last phase backs up the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            if (msg_valid && msg_stall)
            begin
                backed_up <= backed_up + 1;
            end
        end
        else if (!hold_done && beats_taken >= 2 * phase_len + 8)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_stall <= 1'b0;
        end
        else
        begin
            dig_stall <= (hold_left != 0) || ($urandom_range(0, 99) < idle_pct(1'b1));
        end
    end

    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n && dig_valid && !dig_stall)
        begin
            words_checked++;
            if (digest_q.size() == 0)
            begin
                if (err_cnt < 10)
                begin
                    $display("%0t: digest beat %h index %0d final %0b with nothing expected",
                             $realtime, digest_word, word_index, final_word);
                end
                err_cnt++;
            end
            else
            begin
                want = digest_q.pop_front();
                if (digest_word !== want.word || word_index !== want.idx
                    || final_word !== want.fin)
                begin
                    if (err_cnt < 10)
                    begin
                        $display("%0t: expected word %h index %0d final %0b, got %h %0d %0b",
                                 $realtime, want.word, want.idx, want.fin,
                                 digest_word, word_index, final_word);
                    end
                    err_cnt++;
                end
            end
        end
    end

    initial
    begin
        #1_000_000;
        $display("Timed out with %0d digest words outstanding.", digest_q.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        restart_hash();

        // Short messages: empty, partial last words, saturated counts, extreme data.
        push_beat($urandom(), 3'd0, 1'b1);
        push_beat(32'hffff_ffff, 3'd1, 1'b1);
        push_beat(32'hffff_ffff, 3'd2, 1'b1);
        push_beat(32'hffff_ffff, 3'd3, 1'b1);
        push_beat(32'h0000_0000, 3'd4, 1'b1);
        push_beat(32'hffff_ffff, 3'd4, 1'b1);
        push_beat($urandom(), 3'd5, 1'b1);
        push_beat($urandom(), 3'd6, 1'b1);
        push_beat($urandom(), 3'd7, 1'b1);
        push_beat(32'h0000_0000, 3'd7, 1'b0);
        push_beat(32'hffff_ffff, 3'd0, 1'b0);
        push_beat($urandom(), 3'd3, 1'b1);
        push_beat(32'hffff_ffff, 3'd5, 1'b0);
        push_beat(32'h0000_0000, 3'd2, 1'b1);
        msg_cnt = 11;
        longest = 3;

        // Lengths around one block exercise the one- and two-block padding paths.
        while (msg_q.size() < 175)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 5)
            begin
                add_message($urandom_range(1, 6));
            end
            else if (pick < 8)
            begin
                add_message($urandom_range(13, 17));
            end
            else if (pick == 8)
            begin
                add_message($urandom_range(18, 34));
            end
            else
            begin
                add_message($urandom_range(1, 2));
            end
        end
        phase_len = msg_q.size() / 3;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (msg_q.size() != 0 || msg_valid)
        begin
            @(posedge clk);
        end
        while (digest_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100) @(posedge clk);

        $display("Hashed %0d messages in %0d beats (longest %0d words), %0d digest words checked.",
                 msg_cnt, beats_taken, longest, words_checked);
        $display("Message input was held back for %0d cycles behind a stalled digest.",
                 backed_up);
        if (err_cnt == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("%0d mismatches.", err_cnt);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
